// ===== rtl/flash_block_alloc_and_gc_victim_top_macros.svh =====
// assertion macros used by the block table rtl
`ifndef FLASH_BLOCK_ALLOC_AND_GC_VICTIM_TOP_MACROS_SVH
`define FLASH_BLOCK_ALLOC_AND_GC_VICTIM_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FBGC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define FBGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FBGC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define FBGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/fbgc_pkg.sv =====
`timescale 1ns / 1ps

package fbgc_pkg;

    // default geometry
    localparam int CHANNELS_DEF  = 8;
    localparam int WAYS_DEF      = 4;
    localparam int PLANES_DEF    = 2;
    localparam int BLOCKS_DEF    = 1024;
    localparam int MAX_PAGES_DEF = 256;

    // port widths
    localparam int MODE_W    = 2;
    localparam int CH_W      = 3;
    localparam int WAY_W     = 2;
    localparam int PL_W      = 1;
    localparam int BLK_W     = 10;
    localparam int ST_W      = 2;
    localparam int VIN_W     = 9;
    localparam int USED_W    = 11;
    localparam int BIU_W     = 11;
    localparam int PPB_W     = 9;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

    // block status codes
    localparam logic [ST_W-1:0] ST_FREE = 2'd0;
    localparam logic [ST_W-1:0] ST_USED = 2'd1;
    localparam logic [ST_W-1:0] ST_DEAD = 2'd2;
    localparam logic [ST_W-1:0] ST_RSVD = 2'd3;

    // config register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 1'd1;
    localparam logic [BIU_W-1:0]     BIU_RESET           = 11'd1024;
    localparam logic [PPB_W-1:0]     PPB_RESET           = 9'd256;

endpackage

// ===== rtl/flash_block_alloc_and_gc_victim_top.sv =====
// latency: write-entry and no-op words finish one cycle after acceptance, o_done the next
// scans: n = min(blocks_in_use, BLOCKS) entries, one block table read per cycle, so a full
//   scan keeps busy high n+2 cycles and a new word can start every n+3 cycles
// allocation stops early at the first free block; o_done is a one-cycle strobe, no stall
// reset: synchronous, active low; clears control, config and plane records at once
// the block table itself is undefined until written and needs no clearing pass
`timescale 1ns / 1ps
`include "flash_block_alloc_and_gc_victim_top_macros.svh"

module flash_block_alloc_and_gc_victim_top #(
    parameter int CHANNELS  = fbgc_pkg::CHANNELS_DEF,
    parameter int WAYS      = fbgc_pkg::WAYS_DEF,
    parameter int PLANES    = fbgc_pkg::PLANES_DEF,
    parameter int BLOCKS    = fbgc_pkg::BLOCKS_DEF,
    parameter int MAX_PAGES = fbgc_pkg::MAX_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command side
    input  logic                          start,
    output logic                          busy,
    input  logic [fbgc_pkg::MODE_W-1:0]   i_mode,
    input  logic [fbgc_pkg::CH_W-1:0]     i_channel,
    input  logic [fbgc_pkg::WAY_W-1:0]    i_way,
    input  logic [fbgc_pkg::PL_W-1:0]     i_plane,
    input  logic [fbgc_pkg::BLK_W-1:0]    i_block,
    input  logic [fbgc_pkg::ST_W-1:0]     i_status_in,
    input  logic                          i_map_in,
    input  logic [fbgc_pkg::VIN_W-1:0]    i_valid_in,
    // result side
    output logic                          o_done,
    output logic [fbgc_pkg::BLK_W-1:0]    o_block_out,
    output logic                          o_found,
    output logic [fbgc_pkg::VIN_W-1:0]    o_victim_valid,
    output logic [fbgc_pkg::USED_W-1:0]   o_used_count,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [fbgc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fbgc_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int NPL = CHANNELS * WAYS * PLANES;
    localparam int PW  = (NPL > 1) ? $clog2(NPL) : 1;   // plane index bits
    localparam int BW  = $clog2(BLOCKS);                 // block index bits
    localparam int NW  = $clog2(BLOCKS + 1);             // counts up to BLOCKS
    localparam int VW  = $clog2(MAX_PAGES + 1);          // valid page count bits
    localparam int DEPTH = NPL * (2 ** BW);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PLANE = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    typedef struct packed {
        logic [fbgc_pkg::ST_W-1:0] st;
        logic                      mp;
        logic [VW-1:0]             vld;
    } t_entry;

    typedef struct packed {
        logic [BW-1:0] cur;
        logic [NW-1:0] used;
    } t_plane_rec;

    // block table: one entry per plane and block
    t_entry mem [0:DEPTH-1];

    // config
    logic [fbgc_pkg::BIU_W-1:0] r_biu;
    logic [fbgc_pkg::PPB_W-1:0] r_ppb;

    // control
    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_done, n_done;

    // captured word
    logic [fbgc_pkg::MODE_W-1:0] r_mode;
    logic [PW-1:0]               r_p;
    logic                        r_pok;
    logic [fbgc_pkg::BLK_W-1:0]  r_blk;
    logic [fbgc_pkg::ST_W-1:0]   r_st;
    logic                        r_mp;
    logic [fbgc_pkg::VIN_W-1:0]  r_vin;

    // scan state
    logic [BW-1:0] r_cur, n_cur;
    logic [NW-1:0] r_used, n_used;
    logic [NW-1:0] r_len, n_len;
    logic [NW-1:0] r_idx, n_idx;
    logic [VW:0]   r_best, n_best;
    logic          r_found, n_found;
    logic [BW-1:0] r_bidx, n_bidx;
    logic [BW-1:0] r_pend_blk;
    t_entry        r_rd_data;

    // result registers
    logic [fbgc_pkg::BLK_W-1:0]  r_bout, n_bout;
    logic                        r_found_o, n_found_o;
    logic [fbgc_pkg::VIN_W-1:0]  r_vv, n_vv;
    logic [fbgc_pkg::USED_W-1:0] r_used_o, n_used_o;

    // combinational helpers
    logic          acc;
    logic          p_ok;
    logic [PW-1:0] p_calc;
    logic [VW-1:0] lim_c;
    logic [NW-1:0] len_c;
    logic [NW-1:0] used_inc;
    logic          issue;
    logic          last;
    logic          cand;
    logic          ent_we;
    logic [PW+BW-1:0] ent_waddr;
    t_entry        ent_wdata;
    logic          pl_we;
    t_plane_rec    pl_wrec;
    t_plane_rec    plane_rd;
    logic [BW+NW-1:0] plane_rd_raw;

    assign acc  = start && !busy;
    assign busy = (r_state != S_IDLE);

    assign p_ok = (int'(i_channel) < CHANNELS) && (int'(i_way) < WAYS)
                  && (int'(i_plane) < PLANES);
    assign p_calc = PW'((int'(i_channel) * WAYS + int'(i_way)) * PLANES + int'(i_plane));

    // page limit clamped to 1..MAX_PAGES, scan length clamped to BLOCKS
    always_comb begin
        if (r_ppb == '0) begin
            lim_c = VW'(1);
        end else if (32'(r_ppb) > MAX_PAGES) begin
            lim_c = VW'(MAX_PAGES);
        end else begin
            lim_c = VW'(r_ppb);
        end
    end

    assign len_c    = (32'(r_biu) > BLOCKS) ? NW'(BLOCKS) : NW'(r_biu);
    assign used_inc = (32'(r_used) < BLOCKS) ? r_used + NW'(1) : r_used;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= fbgc_pkg::BIU_RESET;
            r_ppb <= fbgc_pkg::PPB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbgc_pkg::CFG_BLOCKS_IN_USE: begin
                    r_biu <= i_cfg_wdata[fbgc_pkg::BIU_W-1:0];
                end
                fbgc_pkg::CFG_PAGES_PER_BLOCK: begin
                    r_ppb <= i_cfg_wdata[fbgc_pkg::PPB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // capture the command word
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mode <= i_mode;
            r_p    <= p_calc;
            r_pok  <= p_ok;
            r_blk  <= i_block;
            r_st   <= i_status_in;
            r_mp   <= i_map_in;
            r_vin  <= i_valid_in;
        end
    end

    // plane records
    fbgc_plane_tbl #(
        .NPL (NPL),
        .PW  (PW),
        .BW  (BW),
        .NW  (NW)
    ) u_plane_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc && p_ok),
        .i_rd_addr (p_calc),
        .o_rd_rec  (plane_rd_raw),
        .i_wr_en   (pl_we),
        .i_wr_addr (r_p),
        .i_wr_rec  (pl_wrec)
    );

    assign plane_rd = t_plane_rec'(plane_rd_raw);

    // main sequencer
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_used    = r_used;
        n_len     = r_len;
        n_idx     = r_idx;
        n_best    = r_best;
        n_found   = r_found;
        n_bidx    = r_bidx;
        n_done    = 1'b0;
        n_bout    = r_bout;
        n_found_o = r_found_o;
        n_vv      = r_vv;
        n_used_o  = r_used_o;
        ent_we    = 1'b0;
        ent_waddr = {r_p, r_pend_blk};
        ent_wdata = '0;
        pl_we     = 1'b0;
        pl_wrec   = '0;
        issue     = 1'b0;
        last      = 1'b0;
        cand      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = S_PLANE;
                end
            end

            S_PLANE: begin
                // plane record is in; set up the scan or finish
                n_cur   = plane_rd.cur;
                n_used  = plane_rd.used;
                n_len   = len_c;
                n_idx   = '0;
                n_best  = {1'b0, lim_c} + (VW+1)'(1);
                n_found = 1'b0;
                n_bidx  = '0;
                n_bout    = '0;
                n_found_o = 1'b0;
                n_vv      = '0;
                n_used_o  = fbgc_pkg::USED_W'(plane_rd.used);
                if (!r_pok) begin
                    // plane address out of range: all zero
                    n_used_o = '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    unique case (r_mode) inside
                        fbgc_pkg::MODE_WRITE: begin
                            if (32'(r_blk) < BLOCKS) begin
                                ent_we        = 1'b1;
                                ent_waddr     = {r_p, BW'(r_blk)};
                                ent_wdata.st  = (r_st == fbgc_pkg::ST_RSVD) ?
                                                fbgc_pkg::ST_DEAD : r_st;
                                ent_wdata.mp  = r_mp;
                                ent_wdata.vld = (32'(r_vin) > 32'(lim_c)) ?
                                                lim_c : VW'(r_vin);
                            end
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                        fbgc_pkg::MODE_ALLOC, fbgc_pkg::MODE_VICTIM: begin
                            if (len_c == '0) begin
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                last = r_pend && ((NW'(r_pend_blk) + NW'(1)) == r_len);
                if (r_mode == fbgc_pkg::MODE_ALLOC) begin
                    if (r_pend && (r_rd_data.st == fbgc_pkg::ST_FREE)) begin
                        // first free block: mark used, make it current
                        ent_we        = 1'b1;
                        ent_wdata.st  = fbgc_pkg::ST_USED;
                        ent_wdata.mp  = r_rd_data.mp;
                        ent_wdata.vld = r_rd_data.vld;
                        pl_we         = 1'b1;
                        pl_wrec.cur   = r_pend_blk;
                        pl_wrec.used  = used_inc;
                        n_bout    = fbgc_pkg::BLK_W'(r_pend_blk);
                        n_found_o = 1'b1;
                        n_used_o  = fbgc_pkg::USED_W'(used_inc);
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end else if (last) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    // greedy pick: strict less-than keeps the lowest index on ties
                    cand = r_pend && (r_rd_data.st == fbgc_pkg::ST_USED) && !r_rd_data.mp
                           && (r_pend_blk != r_cur) && ({1'b0, r_rd_data.vld} < r_best);
                    if (cand) begin
                        n_best  = {1'b0, r_rd_data.vld};
                        n_bidx  = r_pend_blk;
                        n_found = 1'b1;
                    end
                    if (last) begin
                        n_found_o = r_found || cand;
                        n_bout    = fbgc_pkg::BLK_W'(cand ? r_pend_blk : r_bidx);
                        if (cand) begin
                            n_vv = fbgc_pkg::VIN_W'(r_rd_data.vld);
                        end else if (r_found) begin
                            n_vv = fbgc_pkg::VIN_W'(r_best[VW-1:0]);
                        end else begin
                            n_vv = '0;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                // keep one read in flight until the range is covered
                issue = (r_idx < r_len) && (n_state == S_SCAN);
                if (issue) begin
                    n_idx = r_idx + NW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_pend = issue;
    end

    // block table ports
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem[ent_waddr] <= ent_wdata;
        end
        if (issue) begin
            r_rd_data  <= mem[{r_p, r_idx[BW-1:0]}];
            r_pend_blk <= r_idx[BW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= '0;
            r_len     <= '0;
            r_found   <= 1'b0;
            r_found_o <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_done    <= n_done;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_found   <= n_found;
            r_found_o <= n_found_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_used   <= n_used;
        r_best   <= n_best;
        r_bidx   <= n_bidx;
        r_bout   <= n_bout;
        r_vv     <= n_vv;
        r_used_o <= n_used_o;
    end

    assign o_done         = r_done;
    assign o_block_out    = r_bout;
    assign o_found        = r_found_o;
    assign o_victim_valid = r_vv;
    assign o_used_count   = r_used_o;

    // checks
    `FBGC_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `FBGC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `FBGC_ASSERT_IMPLIES(a_none_zero, i_clk, i_rst_n, o_done && !o_found, o_block_out == '0 && o_victim_valid == '0)
    `FBGC_ASSERT_IMPLIES(a_pend_scan, i_clk, i_rst_n, r_pend, r_state == S_SCAN)
    `FBGC_ASSERT_IMPLIES(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= r_len)

endmodule

// ===== rtl/fbgc_plane_tbl.sv =====
`timescale 1ns / 1ps

// per-plane record: current block and used count, valid bits stand in for reset
module fbgc_plane_tbl #(
    parameter int NPL = 64,
    parameter int PW  = 6,
    parameter int BW  = 10,
    parameter int NW  = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [PW-1:0]     i_rd_addr,
    output logic [BW+NW-1:0]  o_rd_rec,
    input  logic              i_wr_en,
    input  logic [PW-1:0]     i_wr_addr,
    input  logic [BW+NW-1:0]  i_wr_rec
);

    typedef struct packed {
        logic [BW-1:0] cur;
        logic [NW-1:0] used;
    } t_plane_rec;

    t_plane_rec       mem [0:NPL-1];
    logic [NPL-1:0]   r_vld;
    t_plane_rec       r_rd_rec;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= t_plane_rec'(i_wr_rec);
        end
        if (i_rd_en) begin
            r_rd_rec <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written plane reads as zero
    assign o_rd_rec = r_rd_hit ? r_rd_rec : '0;

endmodule
